FILE: sv/marp_pkg.sv
`timescale 1ns / 1ps
package marp_pkg;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] DIR_UP      = 2'd0;
  localparam logic [1:0] DIR_DOWN    = 2'd1;
  localparam logic [1:0] DIR_UP_DOWN = 2'd2;
  localparam logic [1:0] DIR_DOWN_UP = 2'd3;

  localparam logic [1:0] REG_DIRECTION     = 2'd0;
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd1;
  localparam logic [1:0] REG_OCTAVE_SPAN   = 2'd2;
  localparam logic [1:0] REG_MIDI_CHANNEL  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef struct packed {
    logic [6:0] note;
    logic [6:0] vel;
  } held_entry_t;
endpackage

FILE: sv/midi_arpeggiator.sv
`timescale 1ns / 1ps
// MIDI arpeggiator. Items are offered on in_cmd/in_note/in_velocity with start;
// a transfer happens when start is high and busy is low. Configuration is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only while
// the block is idle, as the block does not enforce this. Held notes live in a
// NOTE_SLOTS-entry synchronous RAM with a registered read. A release scans the
// RAM one entry per cycle and then shifts the tail down one entry per cycle.
// A tick that runs a step reads the selected entry in S_READ; then the note off
// (if a note sounds) and the note on are each presented for one cycle on
// out_valid, with out_last on the final one. With no notes held, a tick step
// presents only the note off of a sounding note, with out_last.
// Results cannot be held off; the receiver must take each in its cycle.
// Reset clears the count, sequencer state and registers (direction up-down,
// interval 6, span 2, channel 0); RAM contents are not cleared, since only
// entries below the count are ever read.
module midi_arpeggiator #(
  parameter int NOTE_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_cmd,
  input  logic [6:0]                      in_note,
  input  logic [6:0]                      in_velocity,
  input  logic                            cfg_we,
  input  logic [marp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [marp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            out_valid,
  output logic                            out_event_kind,
  output logic [3:0]                      out_channel,
  output logic [6:0]                      out_pitch,
  output logic [6:0]                      out_out_velocity,
  output logic                            out_last
);
  import marp_pkg::*;

  localparam int AW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
  localparam int CW = 5;
  localparam logic [CW-1:0] SLOTS = CW'(NOTE_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OFF   = 3'd4;
  localparam logic [2:0] S_ON    = 3'd5;
  localparam logic [2:0] S_END   = 3'd6;

  held_entry_t mem [NOTE_SLOTS];
  held_entry_t rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  held_entry_t   wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          up_r, up_nxt;
  logic [2:0]    oct_r, oct_nxt;
  logic          snd_r, snd_nxt;
  logic [6:0]    spitch_r, spitch_nxt;
  logic [6:0]    tick_r, tick_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [6:0]    key_r, key_nxt;
  logic [1:0]    dir_r;
  logic [6:0]    ivl_r;
  logic [3:0]    span_r;
  logic [3:0]    chan_r;
  logic [6:0]    on_pitch_r, on_pitch_nxt;
  logic [6:0]    on_vel_r, on_vel_nxt;

  logic [6:0]  tick_inc;
  logic [CW-1:0] cl_idx;
  logic [7:0]  psum;
  logic [3:0]  span_eff;
  logic        wrap;
  logic [3:0]  oct_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_UP_DOWN; ivl_r <= 7'd6; span_r <= 4'd2; chan_r <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION:     dir_r  <= cfg_wdata[1:0];
        REG_STEP_INTERVAL: ivl_r  <= cfg_wdata;
        REG_OCTAVE_SPAN:   span_r <= cfg_wdata[3:0];
        REG_MIDI_CHANNEL:  chan_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign span_eff = (span_r == 4'd0) ? 4'd1 : ((span_r > 4'd8) ? 4'd8 : span_r);
  assign tick_inc = tick_r + 7'd1;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; idx_nxt = idx_r; up_nxt = up_r;
    oct_nxt = oct_r; snd_nxt = snd_r; spitch_nxt = spitch_r; tick_nxt = tick_r;
    ptr_nxt = ptr_r; key_nxt = key_r;
    on_pitch_nxt = on_pitch_r; on_vel_nxt = on_vel_r;
    rd_addr = ptr_r[AW-1:0];
    wr_en = 1'b0; wr_addr = ptr_r[AW-1:0]; wr_data = rd_q;
    out_valid = 1'b0; out_event_kind = 1'b0; out_pitch = 7'd0;
    out_out_velocity = 7'd0; out_last = 1'b0;
    cl_idx = (idx_r >= count_r) ? count_r - CW'(1) : idx_r;
    psum = {1'b0, rd_q.note} + 8'(oct_r) * 8'd12;
    wrap = 1'b0;
    oct_inc = {1'b0, oct_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt = in_note;
          ptr_nxt = '0;
          state_nxt = S_END;
          case (in_cmd)
            CMD_NOTE_ON: begin
              if (in_velocity == 7'd0) begin
                state_nxt = S_SCAN;
              end else if (count_r < SLOTS) begin
                wr_en = 1'b1;
                wr_addr = count_r[AW-1:0];
                wr_data.note = in_note;
                wr_data.vel = in_velocity;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_NOTE_OFF: state_nxt = S_SCAN;
            CMD_TICK: begin
              if (tick_inc >= ivl_r) begin
                tick_nxt = 7'd0;
                if (count_r != '0) begin
                  idx_nxt = cl_idx;
                  rd_addr = cl_idx[AW-1:0];
                  state_nxt = S_READ;
                end else if (snd_r) begin
                  state_nxt = S_OFF;
                end
              end else begin
                tick_nxt = tick_inc;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // rd_q holds entry ptr_r-1 from the previous cycle once ptr_r > 0.
        if (ptr_r != '0 && rd_q.note == key_r) begin
          ptr_nxt = ptr_r;
          rd_addr = ptr_r[AW-1:0];
          state_nxt = S_SHIFT;
        end else if (ptr_r >= count_r) begin
          state_nxt = S_END;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
          rd_addr = ptr_r[AW-1:0];
        end
      end
      S_SHIFT: begin
        // ptr_r is the slot after the hole; rd_q holds it.
        if (ptr_r >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_END;
        end else begin
          wr_en = 1'b1;
          wr_addr = AW'(ptr_r - CW'(1));
          wr_data = rd_q;
          ptr_nxt = ptr_r + CW'(1);
          rd_addr = AW'(ptr_r + CW'(1));
        end
      end
      S_READ: begin
        on_pitch_nxt = (psum > 8'd127) ? 7'd127 : psum[6:0];
        on_vel_nxt = rd_q.vel;
        state_nxt = snd_r ? S_OFF : S_ON;
      end
      S_OFF: begin
        out_valid = 1'b1;
        out_pitch = spitch_r;
        if (count_r == '0) begin
          out_last = 1'b1;
          snd_nxt = 1'b0;
          oct_nxt = 3'd0;
          if (dir_r == DIR_DOWN || dir_r == DIR_DOWN_UP) begin
            idx_nxt = SLOTS; up_nxt = 1'b0;
          end else begin
            idx_nxt = '0; up_nxt = 1'b1;
          end
          state_nxt = S_END;
        end else begin
          state_nxt = S_ON;
        end
      end
      S_ON: begin
        out_valid = 1'b1;
        out_event_kind = 1'b1;
        out_pitch = on_pitch_r;
        out_out_velocity = on_vel_r;
        out_last = 1'b1;
        spitch_nxt = on_pitch_r;
        snd_nxt = 1'b1;
        case (dir_r)
          DIR_UP: begin
            if (idx_r + CW'(1) >= count_r) begin idx_nxt = '0; wrap = 1'b1; end
            else idx_nxt = idx_r + CW'(1);
          end
          DIR_DOWN: begin
            if (idx_r == '0) begin idx_nxt = count_r - CW'(1); wrap = 1'b1; end
            else idx_nxt = idx_r - CW'(1);
          end
          default: begin
            if (up_r) begin
              if (idx_r + CW'(1) >= count_r) begin
                idx_nxt = (count_r > CW'(1)) ? count_r - CW'(2) : '0;
                up_nxt = 1'b0;
                wrap = (dir_r == DIR_DOWN_UP);
              end else idx_nxt = idx_r + CW'(1);
            end else begin
              if (idx_r == '0) begin
                idx_nxt = (count_r > CW'(1)) ? CW'(1) : '0;
                up_nxt = 1'b1;
                wrap = (dir_r == DIR_UP_DOWN);
              end else idx_nxt = idx_r - CW'(1);
            end
          end
        endcase
        if (wrap) oct_inc = {1'b0, oct_r} + 4'd1;
        oct_nxt = (oct_inc >= span_eff) ? 3'd0 : oct_inc[2:0];
        state_nxt = S_END;
      end
      S_END: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; idx_r <= '0; up_r <= 1'b1; oct_r <= 3'd0;
      snd_r <= 1'b0; spitch_r <= 7'd0; tick_r <= 7'd0; ptr_r <= '0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; idx_r <= idx_nxt; up_r <= up_nxt;
      oct_r <= oct_nxt; snd_r <= snd_nxt; spitch_r <= spitch_nxt; tick_r <= tick_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    on_pitch_r <= on_pitch_nxt;
    on_vel_r <= on_vel_nxt;
  end

  assign out_channel = chan_r;
endmodule

FILE: dv/midi_arpeggiator_test.sv
`timescale 1ns / 1ps
module midi_arpeggiator_test;
  import marp_pkg::*;

  localparam int SLOTS       = 16;
  localparam int QUIET_WAIT  = 2 * SLOTS + 8;
  localparam int PHASE_ITEMS = 190;

  typedef struct {
    bit         is_cfg;
    logic [1:0] cmd;
    logic [6:0] note;
    logic [6:0] vel;
    int         idle_pct;
    logic [1:0] reg_idx;
    logic [6:0] reg_val;
  } pending_t;

  typedef struct {
    logic       kind;
    logic [3:0] chan;
    logic [6:0] pitch;
    logic [6:0] vel;
    logic       last;
  } note_msg_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_cmd;
  logic [6:0] in_note;
  logic [6:0] in_velocity;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;
  logic       out_valid;
  logic       out_event_kind;
  logic [3:0] out_channel;
  logic [6:0] out_pitch;
  logic [6:0] out_out_velocity;
  logic       out_last;

  pending_t    pending[$];
  note_msg_t   expected_msgs[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Shadow of the arpeggiator state and registers.
  held_entry_t held[SLOTS];
  int          held_cnt = 0;
  int          seq_pos = 0;
  bit          going_up = 1;
  int          oct_ofs = 0;
  bit          sounding = 0;
  int          sounding_pitch = 0;
  logic [6:0]  ticks = 7'd0;
  logic [1:0]  dir_r = DIR_UP_DOWN;
  logic [6:0]  interval_r = 7'd6;
  logic [3:0]  span_r = 4'd2;
  logic [3:0]  chan_r = 4'd0;

  midi_arpeggiator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_note(in_note), .in_velocity(in_velocity),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_event_kind(out_event_kind),
    .out_channel(out_channel), .out_pitch(out_pitch),
    .out_out_velocity(out_out_velocity), .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic push_msg(input logic kind, input int pitch, input logic [6:0] vel,
                          input logic last);
    note_msg_t m;
    m.kind  = kind;
    m.chan  = chan_r;
    m.pitch = pitch[6:0];
    m.vel   = vel;
    m.last  = last;
    expected_msgs.push_back(m);
  endtask

  task automatic release_note(input logic [6:0] note);
    bit found;
    found = 0;
    for (int i = 0; i < held_cnt; i++) begin
      if (!found && held[i].note == note) begin
        found = 1;
        for (int j = i; j + 1 < held_cnt; j++) held[j] = held[j + 1];
      end
    end
    if (found) held_cnt--;
  endtask

  task automatic run_arp_step();
    int idx;
    int pitch;
    int span;
    bit wrap;
    wrap = 0;
    span = (span_r < 1) ? 1 : (span_r > 8) ? 8 : span_r;
    if (held_cnt > 0) begin
      if (sounding) push_msg(1'b0, sounding_pitch, 7'd0, 1'b0);
      if (seq_pos >= held_cnt) seq_pos = held_cnt - 1;
      pitch = held[seq_pos].note + oct_ofs * 12;
      if (pitch > 127) pitch = 127;
      sounding_pitch = pitch;
      push_msg(1'b1, pitch, held[seq_pos].vel, 1'b1);
      sounding = 1;
      idx = seq_pos;
      case (dir_r)
        DIR_UP: begin
          idx++;
          if (idx >= held_cnt) begin idx = 0; wrap = 1; end
        end
        DIR_DOWN: begin
          idx--;
          if (idx < 0) begin idx = held_cnt - 1; wrap = 1; end
        end
        DIR_UP_DOWN: begin
          if (going_up) begin
            idx++;
            if (idx >= held_cnt) begin
              idx = held_cnt > 1 ? held_cnt - 2 : 0;
              going_up = 0;
            end
          end else begin
            idx--;
            if (idx < 0) begin
              idx = held_cnt > 1 ? 1 : 0;
              going_up = 1;
              wrap = 1;
            end
          end
        end
        default: begin
          if (!going_up) begin
            idx--;
            if (idx < 0) begin
              idx = held_cnt > 1 ? 1 : 0;
              going_up = 1;
            end
          end else begin
            idx++;
            if (idx >= held_cnt) begin
              idx = held_cnt > 1 ? held_cnt - 2 : 0;
              going_up = 0;
              wrap = 1;
            end
          end
        end
      endcase
      seq_pos = idx & 31;
      if (wrap) oct_ofs++;
      if (oct_ofs >= span) oct_ofs = 0;
    end else if (sounding) begin
      push_msg(1'b0, sounding_pitch, 7'd0, 1'b1);
      sounding = 0;
      oct_ofs = 0;
      if (dir_r == DIR_DOWN || dir_r == DIR_DOWN_UP) begin
        seq_pos = SLOTS;
        going_up = 0;
      end else begin
        seq_pos = 0;
        going_up = 1;
      end
    end
  endtask

  task automatic predict_transfer(input logic [1:0] cmd, input logic [6:0] note,
                                  input logic [6:0] vel);
    if (cmd == CMD_NOTE_ON && vel != 0) begin
      if (held_cnt < SLOTS) begin
        held[held_cnt].note = note;
        held[held_cnt].vel  = vel;
        held_cnt++;
      end
    end else if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
      release_note(note);
    end else if (cmd == CMD_TICK) begin
      ticks = ticks + 7'd1;
      if (ticks >= interval_r) begin
        ticks = 7'd0;
        run_arp_step();
      end
    end
  endtask

  // Driver: presents queued transfers and writes registers once the block is quiet.
  always @(posedge clk) begin
    pending_t head;
    bit accepted;
    if (!rst_n) begin
      start  <= 0;
      cfg_we <= 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        predict_transfer(in_cmd, in_note, in_velocity);
        void'(pending.pop_front());
      end
      if (expected_msgs.size() == 0 && !start && !busy) quiet_cycles++;
      else quiet_cycles = 0;
      if (pending.size() == 0) begin
        start  <= 0;
        cfg_we <= 0;
      end else begin
        head = pending[0];
        if (head.is_cfg) begin
          start <= 0;
          if (!accepted && quiet_cycles >= QUIET_WAIT) begin
            cfg_we    <= 1;
            cfg_index <= head.reg_idx;
            cfg_wdata <= head.reg_val;
            case (head.reg_idx)
              REG_DIRECTION:     dir_r      = head.reg_val[1:0];
              REG_STEP_INTERVAL: interval_r = head.reg_val;
              REG_OCTAVE_SPAN:   span_r     = head.reg_val[3:0];
              default:           chan_r     = head.reg_val[3:0];
            endcase
            void'(pending.pop_front());
          end else begin
            cfg_we <= 0;
          end
        end else begin
          cfg_we <= 0;
          if (!start || accepted) begin
            if ($urandom_range(0, 99) < head.idle_pct) begin
              start <= 0;
            end else begin
              start       <= 1;
              in_cmd      <= head.cmd;
              in_note     <= head.note;
              in_velocity <= head.vel;
            end
          end
        end
      end
    end
  end

  // Monitor: every strobed message must match the oldest expectation.
  always @(posedge clk) begin
    note_msg_t exp_msg;
    if (rst_n && out_valid) begin
      if (expected_msgs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected message: kind %0d ch %0d pitch %0d vel %0d last %0d",
                   out_event_kind, out_channel, out_pitch, out_out_velocity, out_last);
      end else begin
        exp_msg = expected_msgs.pop_front();
        if (out_event_kind !== exp_msg.kind || out_channel !== exp_msg.chan ||
            out_pitch !== exp_msg.pitch || out_out_velocity !== exp_msg.vel ||
            out_last !== exp_msg.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("message differs: expected kind %0d ch %0d pitch %0d vel %0d last %0d,",
                     exp_msg.kind, exp_msg.chan, exp_msg.pitch, exp_msg.vel, exp_msg.last);
            $display("  got kind %0d ch %0d pitch %0d vel %0d last %0d",
                     out_event_kind, out_channel, out_pitch, out_out_velocity, out_last);
          end
        end
      end
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [6:0] note,
                            input logic [6:0] vel, input int idle_pct);
    pending_t p;
    p.is_cfg = 0;
    p.cmd = cmd;
    p.note = note;
    p.vel = vel;
    p.idle_pct = idle_pct;
    p.reg_idx = REG_DIRECTION;
    p.reg_val = 7'd0;
    pending.push_back(p);
  endtask

  task automatic queue_cfg(input logic [1:0] idx, input logic [6:0] val);
    pending_t p;
    p.is_cfg = 1;
    p.cmd = CMD_TICK;
    p.note = 7'd0;
    p.vel = 7'd0;
    p.idle_pct = 0;
    p.reg_idx = idx;
    p.reg_val = val;
    pending.push_back(p);
  endtask

  initial begin
    logic [6:0] recent[$];
    logic [6:0] nv;
    int roll;
    int idle_pct;
    int dirs[8]      = '{0, 1, 2, 3, 0, 3, 1, 2};
    int intervals[8] = '{1, 2, 0, 3, 96, 1, 127, 4};
    int spans[8]     = '{1, 8, 0, 15, 3, 2, 5, 4};
    int chans[8]     = '{15, 0, 7, 9, 15, 3, 0, 12};
    rst_n = 0;
    start = 0;
    in_cmd = CMD_TICK;
    in_note = 7'd0;
    in_velocity = 7'd0;
    cfg_we = 0;
    cfg_index = REG_DIRECTION;
    cfg_wdata = 7'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed part: extremes, releases of held and absent notes, the unused
    // command, and steps with and without held or sounding notes.
    queue_cfg(REG_STEP_INTERVAL, 7'd1);
    queue_item(CMD_NOTE_ON, 7'd0, 7'd1, 0);
    queue_item(CMD_NOTE_ON, 7'd127, 7'd127, 0);
    queue_item(CMD_NOTE_ON, 7'd60, 7'd0, 0);
    queue_item(CMD_NOTE_OFF, 7'd33, 7'd0, 0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 0);
    queue_item(CMD_NOTE_OFF, 7'd0, 7'd85, 0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 0);
    queue_item(CMD_NOTE_ON, 7'd127, 7'd0, 0);
    queue_item(CMD_TICK, 7'd127, 7'd127, 0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 0);
    queue_item(CMD_RESERVED, 7'd127, 7'd127, 0);
    queue_item(CMD_NOTE_ON, 7'd85, 7'd42, 0);
    queue_item(CMD_TICK, 7'd42, 7'd85, 0);
    queue_item(CMD_NOTE_OFF, 7'd85, 7'd0, 0);
    queue_item(CMD_TICK, 7'd0, 7'd0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = ph < 3 ? 6 : (ph < 6 ? 77 : 0);
      queue_cfg(REG_DIRECTION, 7'(dirs[ph]));
      queue_cfg(REG_STEP_INTERVAL, 7'(intervals[ph]));
      queue_cfg(REG_OCTAVE_SPAN, 7'(spans[ph]));
      queue_cfg(REG_MIDI_CHANNEL, 7'(chans[ph]));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = int'($urandom_range(0, 99));
        if (roll < 40) begin
          nv = 7'($urandom_range(0, 127));
          recent.push_back(nv);
          if (recent.size() > 24) void'(recent.pop_front());
          queue_item(CMD_NOTE_ON, nv, 7'($urandom_range(1, 127)), idle_pct);
        end else if (roll < 60) begin
          // Mostly release notes that were pressed recently; sometimes a stray one.
          if (recent.size() > 0 && $urandom_range(0, 3) != 0)
            nv = recent[$urandom_range(0, recent.size() - 1)];
          else
            nv = 7'($urandom_range(0, 127));
          if ($urandom_range(0, 1) != 0)
            queue_item(CMD_NOTE_OFF, nv, 7'($urandom_range(0, 127)), idle_pct);
          else
            queue_item(CMD_NOTE_ON, nv, 7'd0, idle_pct);
        end else if (roll < 96) begin
          queue_item(CMD_TICK, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                     idle_pct);
        end else begin
          queue_item(CMD_RESERVED, 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)), idle_pct);
        end
      end
    end

    wait (pending.size() == 0 && expected_msgs.size() == 0 && !start);
    repeat (QUIET_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_msgs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
